>>> rtl/core/plht_pkg.sv
// ----------------------------------------------------------------------------
// plht_pkg
// Types and codes shared by the packet log hit table and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package plht_pkg;

    localparam int PLHT_TABLE_DEPTH = 256;

    // action codes
    localparam logic [1:0] ACT_LOG    = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // status codes
    localparam logic [2:0] STAT_NEW      = 3'd0;
    localparam logic [2:0] STAT_MERGED   = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_READ_OK  = 3'd3;
    localparam logic [2:0] STAT_BAD_IDX  = 3'd4;
    localparam logic [2:0] STAT_CLEARED  = 3'd5;

    typedef enum logic [1:0] {
        PLHT_IDLE,
        PLHT_SCAN,
        PLHT_READ
    } plht_state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now_seconds;
        logic [7:0]         protocol;
        logic               verdict;
        logic [31:0]        source_address;
        logic [31:0]        dest_address;
        logic [15:0]        source_port;
        logic [15:0]        dest_port;
        logic signed [7:0]  why;
        logic [7:0]         read_index;
    } plht_cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [8:0]         entry_total;
        logic [31:0]        entry_time;
        logic [7:0]         entry_protocol;
        logic               entry_verdict;
        logic [31:0]        entry_source_address;
        logic [31:0]        entry_dest_address;
        logic [15:0]        entry_source_port;
        logic [15:0]        entry_dest_port;
        logic signed [7:0]  entry_reason;
        logic [31:0]        entry_hits;
    } plht_result_t;

    // one table row
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        verdict;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [7:0]  reason;
        logic [31:0] time_s;
        logic [31:0] hits;
    } plht_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/packet_log_hit_table_core.sv
// ----------------------------------------------------------------------------
// packet_log_hit_table_core
// Packet event log table with in-order search, hit merging, read and clear.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred on a rising edge with start high and busy low.
//   Each command gives exactly one result, shown on result for one cycle
//   with done high; the receiver cannot hold it off.
//   Log event: the held entries are compared one per cycle, in insertion
//   order, through the single read port of the entry memory. The transfer
//   issues the read of entry 0; the scan ends at a hit or at the last held
//   entry, and then the result and done are registered. On an empty table
//   the row is written at the transfer. Otherwise the matched or appended
//   row is written in the last compare cycle. Read: memory read, then output.
//   Clear, an out-of-range read and the unused code are answered from idle.
//   busy drops in the cycle done is shown, so a new command may be taken
//   then; a miss on a full table of 256 entries compares all 256 first.
//   Reset empties the table at once (fill count to zero); no clearing pass.
//   Rows are only read below the fill count, so the memory needs no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_log_hit_table_core
    import plht_pkg::*;
#(
    parameter int TABLE_DEPTH = PLHT_TABLE_DEPTH
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    input  plht_cmd_t    command,
    output logic         busy,
    output logic         done,
    output plht_result_t result
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    plht_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   cmp_reg, cmp_next;
    logic               done_reg;
    plht_result_t       result_reg;
    plht_cmd_t          req_reg;
    plht_entry_t        rd_data_reg;

    plht_entry_t        mem [TABLE_DEPTH];

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    plht_entry_t        mem_wdata;
    logic               res_fire;
    plht_result_t       res_next;
    logic               req_load;
    logic               hit;
    logic               last_cmp;

    // row match ignores verdict, time and count
    assign hit = (rd_data_reg.src_addr == req_reg.source_address) &&
                 (rd_data_reg.dst_addr == req_reg.dest_address) &&
                 (rd_data_reg.sport == req_reg.source_port) &&
                 (rd_data_reg.dport == req_reg.dest_port) &&
                 (rd_data_reg.protocol == req_reg.protocol) &&
                 (rd_data_reg.reason == req_reg.why);

    assign last_cmp = ((CNT_W'(cmp_reg) + CNT_W'(1)) == fill_reg);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cmp_next   = cmp_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = cmp_reg + IDX_W'(1);
        res_fire   = 1'b0;
        res_next   = '0;
        req_load   = 1'b0;

        unique case (state_reg)
            PLHT_IDLE:
            begin
                if (start)
                begin
                    req_load = 1'b1;
                    unique case (command.action)
                        ACT_LOG:
                        begin
                            if (fill_reg == '0)
                            begin
                                mem_we             = 1'b1;
                                mem_waddr          = '0;
                                mem_wdata.src_addr = command.source_address;
                                mem_wdata.dst_addr = command.dest_address;
                                mem_wdata.verdict  = command.verdict;
                                mem_wdata.sport    = command.source_port;
                                mem_wdata.dport    = command.dest_port;
                                mem_wdata.protocol = command.protocol;
                                mem_wdata.reason   = command.why;
                                mem_wdata.time_s   = command.now_seconds;
                                mem_wdata.hits     = 32'd1;
                                fill_next          = CNT_W'(1);
                                res_fire           = 1'b1;
                                res_next.status    = STAT_NEW;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                cmp_next   = '0;
                                state_next = PLHT_SCAN;
                            end
                        end
                        ACT_READ:
                        begin
                            if (32'(command.read_index) < 32'(fill_reg))
                            begin
                                mem_raddr  = IDX_W'(command.read_index);
                                state_next = PLHT_READ;
                            end
                            else
                            begin
                                res_fire        = 1'b1;
                                res_next.status = STAT_BAD_IDX;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            fill_next       = '0;
                            res_fire        = 1'b1;
                            res_next.status = STAT_CLEARED;
                        end
                        ACT_UNUSED:
                        begin
                            res_fire        = 1'b1;
                            res_next.status = STAT_BAD_IDX;
                        end
                        default:
                        begin
                            res_fire        = 1'b1;
                            res_next.status = STAT_BAD_IDX;
                        end
                    endcase
                end
            end

            PLHT_SCAN:
            begin
                if (hit)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = cmp_reg;
                    mem_wdata        = rd_data_reg;
                    mem_wdata.time_s = req_reg.now_seconds;
                    if (rd_data_reg.hits != '1)
                        mem_wdata.hits = rd_data_reg.hits + 32'd1;
                    res_fire        = 1'b1;
                    res_next.status = STAT_MERGED;
                    state_next      = PLHT_IDLE;
                end
                else if (last_cmp)
                begin
                    if (fill_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        mem_we             = 1'b1;
                        mem_waddr          = IDX_W'(fill_reg);
                        mem_wdata.src_addr = req_reg.source_address;
                        mem_wdata.dst_addr = req_reg.dest_address;
                        mem_wdata.verdict  = req_reg.verdict;
                        mem_wdata.sport    = req_reg.source_port;
                        mem_wdata.dport    = req_reg.dest_port;
                        mem_wdata.protocol = req_reg.protocol;
                        mem_wdata.reason   = req_reg.why;
                        mem_wdata.time_s   = req_reg.now_seconds;
                        mem_wdata.hits     = 32'd1;
                        fill_next          = fill_reg + CNT_W'(1);
                        res_next.status    = STAT_NEW;
                    end
                    res_fire   = 1'b1;
                    state_next = PLHT_IDLE;
                end
                else
                begin
                    cmp_next = cmp_reg + IDX_W'(1);
                end
            end

            PLHT_READ:
            begin
                res_fire                      = 1'b1;
                res_next.status               = STAT_READ_OK;
                res_next.entry_time           = rd_data_reg.time_s;
                res_next.entry_protocol       = rd_data_reg.protocol;
                res_next.entry_verdict        = rd_data_reg.verdict;
                res_next.entry_source_address = rd_data_reg.src_addr;
                res_next.entry_dest_address   = rd_data_reg.dst_addr;
                res_next.entry_source_port    = rd_data_reg.sport;
                res_next.entry_dest_port      = rd_data_reg.dport;
                res_next.entry_reason         = rd_data_reg.reason;
                res_next.entry_hits           = rd_data_reg.hits;
                state_next                    = PLHT_IDLE;
            end

            default:
            begin
                state_next = PLHT_IDLE;
            end
        endcase

        res_next.entry_total = 9'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PLHT_IDLE;
            fill_reg  <= '0;
            cmp_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cmp_reg   <= cmp_next;
            done_reg  <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_load)
            req_reg <= command;
        if (res_fire)
            result_reg <= res_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign busy   = (state_reg != PLHT_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/plht_checker.sv
// ----------------------------------------------------------------------------
// plht_checker
// Port-level checks on the packet log hit table, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plht_checker
    import plht_pkg::*;
(
    input wire          clk,
    input wire          rst_n,
    input wire          start,
    input plht_cmd_t    command,
    input wire          busy,
    input wire          done,
    input plht_result_t result
);

    // a transfer is either answered next cycle or keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("transfer neither answered nor busy");

    // the end of a busy stretch always comes with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy ended without a result");

    // a clear answers at once with an empty table
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command.action == ACT_CLEAR) |=>
            (done && result.status == STAT_CLEARED && result.entry_total == 9'd0))
        else $error("clear not answered as cleared");

    // entry time, hits and addresses stay zero outside a successful read
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STAT_READ_OK) |->
            (result.entry_time == 32'd0 && result.entry_hits == 32'd0 &&
             result.entry_source_address == 32'd0 &&
             result.entry_dest_address == 32'd0))
        else $error("entry fields set outside a read");

    // no result while idle without a transfer in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
        else $error("result without a command");

endmodule

bind packet_log_hit_table_core plht_checker u_plht_checker (.*);

`default_nettype wire
